// ===== src/akfd_pkg.sv =====
// Shared types, constants and helper functions for the ADC keypad filter and decoder.
package akfd_pkg;

  // Field and datapath widths
  localparam int SAMPLE_BITS   = 10;
  localparam int HISTORY_DEPTH = 3;
  localparam int HIST_IDX_BITS = 2;
  localparam int LEVEL_BITS    = 8;
  localparam int TOL_BITS      = 10;
  localparam int KEY_BITS      = 3;
  localparam int AVG_SHIFT     = 4;
  localparam int SUM_BITS      = SAMPLE_BITS + 2;

  // APB port geometry
  localparam int APB_ADDR_BITS = 5;
  localparam int APB_DATA_BITS = 32;
  localparam int REG_IDX_LSB   = 2;

  // Reset values of the configuration registers
  localparam logic [LEVEL_BITS-1:0] CENTER_UP_RST     = 8'd32;
  localparam logic [LEVEL_BITS-1:0] CENTER_DOWN_RST   = 8'd76;
  localparam logic [LEVEL_BITS-1:0] CENTER_LEFT_RST   = 8'd120;
  localparam logic [LEVEL_BITS-1:0] CENTER_RIGHT_RST  = 8'd0;
  localparam logic [LEVEL_BITS-1:0] CENTER_SELECT_RST = 8'd180;
  localparam logic [LEVEL_BITS-1:0] KEY_WINDOW_RST    = 8'd8;
  localparam logic [TOL_BITS-1:0]   AGREE_TOL_RST     = 10'd8;

  // Key codes as seen on the result channel
  typedef enum logic [KEY_BITS-1:0] {
    KEY_UP     = 3'd0,
    KEY_DOWN   = 3'd1,
    KEY_LEFT   = 3'd2,
    KEY_RIGHT  = 3'd3,
    KEY_SELECT = 3'd4,
    KEY_NONE   = 3'd5
  } key_e;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_CENTER_UP     = 3'd0,
    REG_CENTER_DOWN   = 3'd1,
    REG_CENTER_LEFT   = 3'd2,
    REG_CENTER_RIGHT  = 3'd3,
    REG_CENTER_SELECT = 3'd4,
    REG_KEY_WINDOW    = 3'd5,
    REG_AGREE_TOL     = 3'd6
  } reg_idx_e;

  // Configuration handed from the register file to the datapath
  typedef struct packed {
    logic [LEVEL_BITS-1:0] center_up;
    logic [LEVEL_BITS-1:0] center_down;
    logic [LEVEL_BITS-1:0] center_left;
    logic [LEVEL_BITS-1:0] center_right;
    logic [LEVEL_BITS-1:0] center_select;
    logic [LEVEL_BITS-1:0] key_window;
    logic [TOL_BITS-1:0]   agree_tol;
  } akfd_cfg_t;

  function automatic logic [SAMPLE_BITS-1:0] absdiff_sample(
    input logic [SAMPLE_BITS-1:0] a,
    input logic [SAMPLE_BITS-1:0] b
  );
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [LEVEL_BITS-1:0] absdiff_level(
    input logic [LEVEL_BITS-1:0] a,
    input logic [LEVEL_BITS-1:0] b
  );
    return (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

// ===== src/akfd_regs.sv =====
// APB configuration register file for the keypad decoder.
module akfd_regs
  import akfd_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output akfd_cfg_t                cfg_o
);

  akfd_cfg_t cfg_q;
  akfd_cfg_t cfg_d;
  reg_idx_e  reg_idx;
  logic      wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[APB_ADDR_BITS-1:REG_IDX_LSB]);
  assign wr_en   = psel && penable && pwrite;
  assign cfg_o   = cfg_q;

  // Update the addressed register on a write transfer
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_CENTER_UP:     cfg_d.center_up     = pwdata[LEVEL_BITS-1:0];
        REG_CENTER_DOWN:   cfg_d.center_down   = pwdata[LEVEL_BITS-1:0];
        REG_CENTER_LEFT:   cfg_d.center_left   = pwdata[LEVEL_BITS-1:0];
        REG_CENTER_RIGHT:  cfg_d.center_right  = pwdata[LEVEL_BITS-1:0];
        REG_CENTER_SELECT: cfg_d.center_select = pwdata[LEVEL_BITS-1:0];
        REG_KEY_WINDOW:    cfg_d.key_window    = pwdata[LEVEL_BITS-1:0];
        REG_AGREE_TOL:     cfg_d.agree_tol     = pwdata[TOL_BITS-1:0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_up     <= CENTER_UP_RST;
      cfg_q.center_down   <= CENTER_DOWN_RST;
      cfg_q.center_left   <= CENTER_LEFT_RST;
      cfg_q.center_right  <= CENTER_RIGHT_RST;
      cfg_q.center_select <= CENTER_SELECT_RST;
      cfg_q.key_window    <= KEY_WINDOW_RST;
      cfg_q.agree_tol     <= AGREE_TOL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Return the addressed register, zero-extended
  always_comb begin
    case (reg_idx)
      REG_CENTER_UP:     prdata = APB_DATA_BITS'(cfg_q.center_up);
      REG_CENTER_DOWN:   prdata = APB_DATA_BITS'(cfg_q.center_down);
      REG_CENTER_LEFT:   prdata = APB_DATA_BITS'(cfg_q.center_left);
      REG_CENTER_RIGHT:  prdata = APB_DATA_BITS'(cfg_q.center_right);
      REG_CENTER_SELECT: prdata = APB_DATA_BITS'(cfg_q.center_select);
      REG_KEY_WINDOW:    prdata = APB_DATA_BITS'(cfg_q.key_window);
      REG_AGREE_TOL:     prdata = APB_DATA_BITS'(cfg_q.agree_tol);
      default:           prdata = '0;
    endcase
  end

endmodule

// ===== src/akfd_core.sv =====
// Sample register, history filter, key classifier and result register.
module akfd_core
  import akfd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  akfd_cfg_t              cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [KEY_BITS-1:0]    key_code_o
);

  logic                     in_valid_q;
  logic [SAMPLE_BITS-1:0]   sample_q;
  logic                     out_valid_q;
  key_e                     held_q;
  key_e                     held_d;
  logic [SAMPLE_BITS-1:0]   hist_q [HISTORY_DEPTH];
  logic [HIST_IDX_BITS-1:0] count_q;
  logic [HIST_IDX_BITS-1:0] count_d;
  logic [HIST_IDX_BITS-1:0] wr_idx;

  logic                     advance;
  logic                     step;
  logic [HISTORY_DEPTH-1:0] agree;
  logic                     all_agree;
  logic                     full_match;
  logic [SUM_BITS-1:0]      sum;
  logic [LEVEL_BITS-1:0]    level;
  key_e                     key_class;

  // Result register frees up when empty or taken this cycle
  assign advance     = !out_valid_q || out_ready_i;
  assign step        = in_valid_q && advance;
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign key_code_o  = held_q;

  // Compare the new sample with every stored one that is valid
  always_comb begin
    all_agree = 1'b1;
    for (int j = 0; j < HISTORY_DEPTH; j++) begin
      agree[j] = absdiff_sample(sample_q, hist_q[j]) <= cfg_i.agree_tol;
      if ((HIST_IDX_BITS'(j) < count_q) && !agree[j]) begin
        all_agree = 1'b0;
      end
    end
  end

  assign full_match = (count_q == HIST_IDX_BITS'(HISTORY_DEPTH)) && all_agree;

  // Average four agreeing samples down to an 8-bit level
  always_comb begin
    sum = SUM_BITS'(sample_q);
    for (int j = 0; j < HISTORY_DEPTH; j++) begin
      sum = sum + SUM_BITS'(hist_q[j]);
    end
  end

  assign level = sum[AVG_SHIFT +: LEVEL_BITS];

  // Classify the level, first matching window wins
  always_comb begin
    if (absdiff_level(level, cfg_i.center_up) < cfg_i.key_window) begin
      key_class = KEY_UP;
    end else if (absdiff_level(level, cfg_i.center_down) < cfg_i.key_window) begin
      key_class = KEY_DOWN;
    end else if (absdiff_level(level, cfg_i.center_left) < cfg_i.key_window) begin
      key_class = KEY_LEFT;
    end else if (absdiff_level(level, cfg_i.center_right) < cfg_i.key_window) begin
      key_class = KEY_RIGHT;
    end else if (absdiff_level(level, cfg_i.center_select) < cfg_i.key_window) begin
      key_class = KEY_SELECT;
    end else begin
      key_class = KEY_NONE;
    end
  end

  // Restart the history on a full match or a disagreement, else append
  assign wr_idx  = (full_match || !all_agree) ? '0 : count_q;
  assign count_d = wr_idx + HIST_IDX_BITS'(1);
  assign held_d  = full_match ? key_class : held_q;

  // Control state: input stage, result stage, fill count and held key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      held_q      <= KEY_NONE;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (step) begin
        out_valid_q <= 1'b1;
        count_q     <= count_d;
        held_q      <= held_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: capture the sample, store it into the history
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sample_q <= sample_i;
    end
    if (step) begin
      hist_q[wr_idx] <= sample_q;
    end
  end

`ifndef SYNTHESIS
  // Every processed sample leaves at least itself in the history
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> (count_q != '0))
    else $error("history empty after a processed sample");

  // Fill count moves only when a sample is processed
  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> $stable(count_q))
    else $error("history count changed without a transfer");

  // Held key changes only after a full four-sample match
  a_key_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(held_q) |-> $past(step && full_match))
    else $error("held key changed without a full match");

  // A stalled result keeps its key
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> $stable(held_q))
    else $error("result changed while stalled");
`endif

endmodule

// ===== src/adc_keypad_filter_decoder.sv =====
// Top level of the ADC keypad filter and decoder.
//
//   channel  signals                              direction  transfer when
//   input    in_valid_i, in_ready_o, sample_i     in         in_valid_i & in_ready_o
//   result   out_valid_o, out_ready_i, key_code_o out        out_valid_o & out_ready_i
//   config   psel, penable, pwrite, paddr, ...    in         psel & penable & pwrite
//
// Each sample passes through the input register and then the result
// register; the filter and classifier sit between them, so a new sample is
// taken every cycle while the result side keeps up.
// A stalled result holds the result register; one more sample waits in the
// input register, after which in_ready_o drops.
// Reset empties both stages, clears the history and sets the held key to none.
module adc_keypad_filter_decoder
  import akfd_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [SAMPLE_BITS-1:0]   sample_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [KEY_BITS-1:0]      key_code_o
);

  akfd_cfg_t cfg;

  // Configuration registers
  akfd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Filter and classifier datapath
  akfd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .key_code_o  (key_code_o)
  );

endmodule
